@@ hw/rtl/rn_pkg.sv @@
// ----------------------------------------------------------------------------
// rn_pkg
// Shared types for the rational normalizer: result status codes, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rn_pkg;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_DEN_ZERO = 2'd1,
    STS_RANGE    = 2'd2
  } rn_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TWOS,
    S_GCD,
    S_SETG,
    S_DIV_A,
    S_DIV_B,
    S_FIN
  } rn_state_t;

  typedef struct packed {
    logic load;
    logic twos_step;
    logic gcd_step;
    logic set_g;
    logic div_start;
    logic div_sel_b;
    logic div_step;
    logic save_qa;
    logic out_load;
  } rn_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic twos_done;
    logic gcd_done;
    logic div_done;
  } rn_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/rn_if.sv @@
// ----------------------------------------------------------------------------
// rn_in_if / rn_out_if
// Valid/ready channels of the rational normalizer: the fraction going in and
// the reduced fraction with its status coming out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rn_in_if #(
  parameter int WIDTH = 32
) ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] num_in;
  logic [WIDTH-1:0] den_in;

  modport source (output valid, output num_in, output den_in, input ready);
  modport sink   (input valid, input num_in, input den_in, output ready);
endinterface

interface rn_out_if
  import rn_pkg::*;
#(
  parameter int WIDTH = 32
) ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] num_out;
  logic [WIDTH-2:0] den_out;
  rn_status_t       status;

  modport source (output valid, output num_out, output den_out, output status,
                  input ready);
  modport sink   (input valid, input num_out, input den_out, input status,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rn_dp.sv @@
// ----------------------------------------------------------------------------
// rn_dp
// Datapath of the rational normalizer: operand magnitudes, binary gcd
// registers, a shared restoring divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rn_dp
  import rn_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  rn_cmd_t          cmd,
  output rn_sts_t          sts,
  input  logic [WIDTH-1:0] num_in,
  input  logic [WIDTH-1:0] den_in,
  output logic [WIDTH-1:0] num_out,
  output logic [WIDTH-2:0] den_out,
  output rn_status_t       status
);

  localparam int KW = $clog2(WIDTH);
  localparam int CW = $clog2(WIDTH + 1);
  localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

  logic [WIDTH-1:0] a_r, b_r, x_r, y_r, g_r, q_r, rem_r, qa_r;
  logic [KW-1:0]    k_r;
  logic [CW-1:0]    cnt_r;
  logic             neg_r, zero_r;

  logic [WIDTH-1:0] num_mag, den_mag, dividend, neg_qa;
  logic [WIDTH:0]   rem_sh, diff;

  logic [WIDTH-1:0] num_out_r;
  logic [WIDTH-2:0] den_out_r;
  rn_status_t       status_r;

  assign num_mag  = num_in[WIDTH-1] ? (~num_in) + ONE : num_in;
  assign den_mag  = den_in[WIDTH-1] ? (~den_in) + ONE : den_in;
  assign dividend = cmd.div_sel_b ? b_r : a_r;
  assign rem_sh   = {rem_r, q_r[WIDTH-1]};
  assign diff     = rem_sh - {1'b0, g_r};
  assign neg_qa   = (~qa_r) + ONE;

  assign sts.den_zero  = zero_r;
  assign sts.twos_done = x_r[0] | y_r[0];
  assign sts.gcd_done  = (x_r == '0) || (y_r == '0);
  assign sts.div_done  = (cnt_r == CW'(WIDTH));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r    <= num_mag;
      b_r    <= den_mag;
      x_r    <= num_mag;
      y_r    <= den_mag;
      k_r    <= '0;
      neg_r  <= num_in[WIDTH-1] ^ den_in[WIDTH-1];
      zero_r <= (den_in == '0);
    end else if (cmd.twos_step) begin
      x_r <= x_r >> 1;
      y_r <= y_r >> 1;
      k_r <= k_r + KW'(1);
    end else if (cmd.gcd_step) begin
      if (!x_r[0]) begin
        x_r <= x_r >> 1;
      end else if (!y_r[0]) begin
        y_r <= y_r >> 1;
      end else if (x_r >= y_r) begin
        x_r <= x_r - y_r;
      end else begin
        y_r <= y_r - x_r;
      end
    end

    if (cmd.set_g) begin
      g_r <= (x_r | y_r) << k_r;
    end

    if (cmd.save_qa) begin
      qa_r <= q_r;
    end

    if (cmd.div_start) begin
      q_r   <= dividend;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + CW'(1);
      if (!diff[WIDTH]) begin
        rem_r <= diff[WIDTH-1:0];
        q_r   <= {q_r[WIDTH-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[WIDTH-1:0];
        q_r   <= {q_r[WIDTH-2:0], 1'b0};
      end
    end

    if (cmd.out_load) begin
      if (zero_r) begin
        num_out_r <= '0;
        den_out_r <= '0;
        status_r  <= STS_DEN_ZERO;
      end else if (qa_r[WIDTH-1] || q_r[WIDTH-1]) begin
        num_out_r <= '0;
        den_out_r <= '0;
        status_r  <= STS_RANGE;
      end else begin
        num_out_r <= (neg_r && (qa_r != '0)) ? neg_qa : qa_r;
        den_out_r <= q_r[WIDTH-2:0];
        status_r  <= STS_OK;
      end
    end
  end

  assign num_out = num_out_r;
  assign den_out = den_out_r;
  assign status  = status_r;

endmodule

`default_nettype wire

@@ hw/rtl/rn_ctrl.sv @@
// ----------------------------------------------------------------------------
// rn_ctrl
// Controller of the rational normalizer: sequences input transfer, gcd
// search, the two divisions and the result register handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module rn_ctrl
  import rn_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  rn_sts_t sts,
  output rn_cmd_t cmd
);

  rn_state_t state_r, state_nxt;
  logic      out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_TWOS;
        end
      end
      S_TWOS: begin
        if (sts.den_zero) begin
          state_nxt = S_FIN;
        end else if (sts.twos_done) begin
          state_nxt = S_GCD;
        end else begin
          cmd.twos_step = 1'b1;
        end
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          state_nxt = S_SETG;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_SETG: begin
        cmd.set_g     = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_A;
      end
      S_DIV_A: begin
        if (sts.div_done) begin
          cmd.save_qa   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel_b = 1'b1;
          state_nxt     = S_DIV_B;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DIV_B: begin
        if (sts.div_done) begin
          state_nxt = S_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ hw/rtl/rational_normalizer.sv @@
// ----------------------------------------------------------------------------
// rational_normalizer
// Reduces a signed fraction to lowest terms with a positive denominator.
// ----------------------------------------------------------------------------
// One fraction is in flight at a time. After the input transfer the block
// strips common factors of two, runs a binary gcd on the magnitudes (one
// shift or subtract per cycle), then divides numerator and denominator by
// the gcd in one shared restoring divider at one quotient bit per cycle. A
// zero denominator skips the factor stripping, the gcd search and both
// divisions. The result register holds a finished result while the next
// fraction is being accepted and worked on. Status 1 flags a zero
// denominator, status 2 a reduced value whose magnitude reaches
// 2^(WIDTH-1); both return zero in num_out and den_out.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_normalizer
  import rn_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  rn_in_if.sink    in_chan,
  rn_out_if.source out_chan
);

  rn_cmd_t cmd;
  rn_sts_t sts;

  rn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rn_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .sts     (sts),
    .num_in  (in_chan.num_in),
    .den_in  (in_chan.den_in),
    .num_out (out_chan.num_out),
    .den_out (out_chan.den_out),
    .status  (out_chan.status)
  );

  // one fraction at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("input accepted twice in a row");

  // error results carry zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.status != STS_OK) |->
      (out_chan.num_out == '0) && (out_chan.den_out == '0))
    else $error("error result with nonzero fields");

  // good results have a nonzero denominator
  a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.status == STS_OK) |-> (out_chan.den_out != '0))
    else $error("ok result with zero denominator");

  // result never uses the unassigned status code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.status == STS_OK) ||
      (out_chan.status == STS_DEN_ZERO) || (out_chan.status == STS_RANGE))
    else $error("bad status code");

endmodule

`default_nettype wire
